### rtl/assert_macros.svh
// Assertion helpers shared by the PWM controller RTL.
// Depends on nothing; every macro samples on clk and disables on rst_n low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked only once reset has been released.
`define PWMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked on the next clock.
`define PWMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PWMC_ASSERT(lbl, prop, msg)
`define PWMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pwmc_pkg.sv
// Shared types and constants of the 16-channel PWM controller.
// Used by pwmc_front, pwmc_back and pwm_controller_16ch; depends on nothing.
`timescale 1ns / 1ps
package pwmc_pkg;

  // Item classes decoded by the front end.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_PTR = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam int PWM_W  = 12;
  localparam int OUT_W  = 16;
  localparam int Q_DEPTH = 2;

  // Register map.
  localparam logic [7:0] ADDR_MODE1    = 8'h00;
  localparam logic [7:0] ADDR_MODE2    = 8'h01;
  localparam logic [7:0] ADDR_LED_BASE = 8'h06;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

  // Mode bits.
  localparam int M1_RESTART_BIT = 7;
  localparam int M1_AI_BIT      = 5;
  localparam int M1_SLEEP_BIT   = 4;
  localparam int M2_INVRT_BIT   = 4;

  localparam logic [7:0] MODE1_RESET    = 8'h11;
  localparam logic [7:0] MODE2_RESET    = 8'h04;
  localparam logic [7:0] PRESCALE_RESET = 8'h1E;
  localparam logic [7:0] PRESCALE_MIN   = 8'd3;
  localparam logic [7:0] MODE1_WMASK    = 8'h7F;
  localparam logic [7:0] MODE2_WMASK    = 8'h1F;

  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [OUT_W-1:0] pwm_outputs;
    logic [PWM_W-1:0] pwm_count;
  } result_t;

endpackage

### rtl/pwmc_fifo.sv
// Small register queue used between the front end, back end and result port.
// Depends on assert_macros.svh only.
`timescale 1ns / 1ps
module pwmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `PWMC_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "fifo count above depth")
  `PWMC_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_r == $past(count_r) + 1'b1,
    "fifo count did not grow on push")
  `PWMC_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_r == $past(count_r) - 1'b1,
    "fifo count did not shrink on pop")
endmodule

### rtl/pwmc_front.sv
// Front end: takes input beats, classifies them and queues them for the back end.
// Depends on pwmc_pkg and pwmc_fifo.
`timescale 1ns / 1ps
module pwmc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      in_kind,
  input  logic [7:0]      in_reg_address,
  input  logic [7:0]      in_data_byte,
  input  logic            q_pop,
  output logic            q_empty,
  output pwmc_pkg::item_t q_item
);
  import pwmc_pkg::*;

  item_t item;

  // Kind decode: the kind field maps one to one onto the item class
  always_comb begin
    item.addr = in_reg_address;
    item.data = in_data_byte;
    item.op   = op_t'(in_kind);
  end

  pwmc_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );
endmodule

### rtl/pwmc_back.sv
// Back end: register file, prescaler, period counter and channel level compare.
// Depends on pwmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module pwmc_back #(
  parameter int CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_empty,
  input  pwmc_pkg::item_t   item,
  output logic              item_pop,
  input  logic              res_full,
  output logic              res_push,
  output pwmc_pkg::result_t res_data
);
  import pwmc_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]       mode_one_r, mode_one_nxt;
  logic [7:0]       mode_two_r, mode_two_nxt;
  logic [7:0]       prescale_r, prescale_nxt;
  logic [7:0]       ptr_r, ptr_nxt;
  logic [7:0]       div_r, div_nxt;
  logic [PWM_W-1:0] period_r, period_nxt;
  logic [PWM_W-1:0] on_r  [CHANNELS];
  logic [PWM_W-1:0] off_r [CHANNELS];

  logic             s1_valid_r;
  logic [7:0]       rd_r, rd_nxt;

  logic             fire;
  logic [7:0]       led_off;
  logic             led_hit;
  logic [CW-1:0]    led_idx;
  logic [PWM_W-1:0] led_cur;
  logic             led_we;
  logic             restart_flag;
  logic [OUT_W-1:0] levels;

  // Stage 1 may take an item when its result slot is free or draining
  assign fire     = !item_empty && (!s1_valid_r || !res_full);
  assign item_pop = fire;
  assign res_push = s1_valid_r;

  // Channel register decode at the pointer
  assign led_off = ptr_r - ADDR_LED_BASE;
  assign led_hit = (ptr_r >= ADDR_LED_BASE) && ({2'b00, led_off[7:2]} < 8'(CHANNELS));
  assign led_idx = led_off[CW+1:2];
  assign led_cur = led_off[1] ? off_r[led_idx] : on_r[led_idx];
  assign led_we  = fire && (item.op == OP_WRITE) && led_hit;

  // MODE1 write: restart latches on a sleep entry, clears on a write of bit 7 with sleep clear
  always_comb begin
    restart_flag = mode_one_r[M1_RESTART_BIT];
    if (!mode_one_r[M1_SLEEP_BIT] && item.data[M1_SLEEP_BIT]) begin
      restart_flag = 1'b1;
    end
    if (item.data[M1_RESTART_BIT] && !item.data[M1_SLEEP_BIT]) begin
      restart_flag = 1'b0;
    end
  end

  // Item execution
  always_comb begin
    mode_one_nxt = mode_one_r;
    mode_two_nxt = mode_two_r;
    prescale_nxt = prescale_r;
    ptr_nxt      = ptr_r;
    div_nxt      = div_r;
    period_nxt   = period_r;
    rd_nxt       = '0;
    if (fire) begin
      unique case (item.op)
        OP_TICK: begin
          if (!mode_one_r[M1_SLEEP_BIT]) begin
            if (div_r >= prescale_r) begin
              div_nxt    = '0;
              period_nxt = period_r + 1'b1;
            end else begin
              div_nxt = div_r + 1'b1;
            end
          end
        end
        OP_SET_PTR: begin
          ptr_nxt = item.addr;
        end
        OP_WRITE: begin
          if (ptr_r == ADDR_MODE1) begin
            mode_one_nxt = (item.data & MODE1_WMASK) |
                           {restart_flag, 7'b0};
          end else if (ptr_r == ADDR_MODE2) begin
            mode_two_nxt = item.data & MODE2_WMASK;
          end else if (ptr_r == ADDR_PRESCALE) begin
            if (mode_one_r[M1_SLEEP_BIT]) begin
              prescale_nxt = (item.data < PRESCALE_MIN) ? PRESCALE_MIN : item.data;
            end
          end
          if (mode_one_nxt[M1_AI_BIT]) begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        OP_READ: begin
          if (ptr_r == ADDR_MODE1) begin
            rd_nxt = mode_one_r;
          end else if (ptr_r == ADDR_MODE2) begin
            rd_nxt = mode_two_r;
          end else if (ptr_r == ADDR_PRESCALE) begin
            rd_nxt = prescale_r;
          end else if (led_hit) begin
            rd_nxt = led_off[0] ? {4'b0, led_cur[PWM_W-1:8]} : led_cur[7:0];
          end
          if (mode_one_r[M1_AI_BIT]) begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_one_r <= MODE1_RESET;
      mode_two_r <= MODE2_RESET;
      prescale_r <= PRESCALE_RESET;
      ptr_r      <= '0;
      div_r      <= '0;
      period_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      mode_one_r <= mode_one_nxt;
      mode_two_r <= mode_two_nxt;
      prescale_r <= prescale_nxt;
      ptr_r      <= ptr_nxt;
      div_r      <= div_nxt;
      period_r   <= period_nxt;
      s1_valid_r <= fire || (s1_valid_r && res_full);
    end
  end

  // Read data rides along with the stage 1 beat
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r <= rd_nxt;
    end
  end

  // Per-channel on/off counts, byte-wide writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_r[i]  <= '0;
        off_r[i] <= '0;
      end
    end else if (led_we) begin
      if (led_off[1]) begin
        if (led_off[0]) off_r[led_idx][PWM_W-1:8] <= item.data[3:0];
        else            off_r[led_idx][7:0]       <= item.data;
      end else begin
        if (led_off[0]) on_r[led_idx][PWM_W-1:8] <= item.data[3:0];
        else            on_r[led_idx][7:0]       <= item.data;
      end
    end
  end

  // Channel levels from the state left by the stage 1 beat
  always_comb begin
    logic active;
    logic hi;
    active = !(mode_one_r[M1_SLEEP_BIT] || mode_one_r[M1_RESTART_BIT]);
    levels = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      if (on_r[n] < off_r[n]) begin
        hi = (period_r >= on_r[n]) && (period_r < off_r[n]);
      end else if (on_r[n] > off_r[n]) begin
        hi = (period_r >= on_r[n]) || (period_r < off_r[n]);
      end else begin
        hi = 1'b0;
      end
      levels[n] = (hi && active) ^ mode_two_r[M2_INVRT_BIT];
    end
  end

  assign res_data.read_data   = rd_r;
  assign res_data.pwm_outputs = levels;
  assign res_data.pwm_count   = period_r;

  `PWMC_ASSERT(a_prescale_min, prescale_r >= PRESCALE_MIN, "prescale below minimum")
  `PWMC_ASSERT(a_mode2_upper, mode_two_r[7:5] == 3'b000, "MODE2 upper bits set")
  `PWMC_ASSERT_NEXT(a_sleep_hold, mode_one_r[M1_SLEEP_BIT],
    $stable(div_r) && $stable(period_r), "counters moved while asleep")
  `PWMC_ASSERT_NEXT(a_stall_hold, s1_valid_r && res_full,
    s1_valid_r && $stable(rd_r), "stalled result beat was lost")
endmodule

### rtl/pwm_controller_16ch.sv
// Top level of the 16-channel 12-bit PWM controller.
// Depends on pwmc_pkg, pwmc_front, pwmc_back and pwmc_fifo.
`timescale 1ns / 1ps
// Each input beat (oscillator tick, pointer load, byte write or byte read) yields
// exactly one result beat carrying the read byte, all channel levels and the period
// counter as they stand after that beat. One beat is taken every clock cycle while
// the input queue is not full; the back end executes one beat per cycle while its
// result slot is free or draining, so throughput is one item per cycle without stalls.
// A pushed beat passes through the input queue, then the execute register, into the
// result queue that drives the output. Both sides are two-entry queues and the execute
// register holds one more, so a stalled reader holds back the writer only once five beats pile up.
module pwm_controller_16ch #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_reg_address,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_pwm_outputs,
  output logic [11:0] out_pwm_count
);
  import pwmc_pkg::*;

  item_t   q_item;
  logic    q_empty, q_pop;
  result_t res_data, res_out;
  logic    res_push, res_full;

  pwmc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_reg_address (in_reg_address),
    .in_data_byte   (in_data_byte),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_item         (q_item)
  );

  pwmc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (q_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  pwmc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_read_data   = res_out.read_data;
  assign out_pwm_outputs = res_out.pwm_outputs;
  assign out_pwm_count   = res_out.pwm_count;
endmodule

### tb/sv/tb_pwm_controller_16ch.sv
// Self-checking testbench for the 16-channel PWM controller (pwm_controller_16ch).
// Depends on pwmc_pkg and the RTL under rtl; a shadow of the register map predicts every
// result beat, which is checked field by field against the block's output queue.
`timescale 1ns / 1ps
module tb_pwm_controller_16ch;
  import pwmc_pkg::*;

  localparam int CHANNELS    = 16;
  localparam int PHASE_BEATS = 150;
  localparam int FAST_TICKS  = 64;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_kind;
  logic [7:0]  in_reg_address;
  logic [7:0]  in_data_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_read_data;
  logic [15:0] out_pwm_outputs;
  logic [11:0] out_pwm_count;

  // Shadow copy of the register map, prescaler and period counter
  class pwm_shadow;
    logic [7:0]  mode1;
    logic [7:0]  mode2;
    logic [7:0]  prescale;
    logic [7:0]  pointer;
    logic [7:0]  divider;
    logic [11:0] period;
    logic [11:0] on_count [CHANNELS];
    logic [11:0] off_count [CHANNELS];
    result_t     predicted_beats [$];
    int unsigned mismatches;

    function new();
      mode1      = MODE1_RESET;
      mode2      = MODE2_RESET;
      prescale   = PRESCALE_RESET;
      pointer    = '0;
      divider    = '0;
      period     = '0;
      mismatches = 0;
      foreach (on_count[n]) begin
        on_count[n]  = '0;
        off_count[n] = '0;
      end
    endfunction

    // Channel register decode: channel index and byte slot (ON_L, ON_H, OFF_L, OFF_H)
    function bit led_slot(input logic [7:0] addr, output int unsigned ch,
                          output int unsigned slot);
      logic [7:0] rel;
      ch   = 0;
      slot = 0;
      if (addr < ADDR_LED_BASE) return 1'b0;
      rel = addr - ADDR_LED_BASE;
      if ((rel >> 2) >= CHANNELS) return 1'b0;
      ch   = 32'(rel >> 2);
      slot = 32'(rel & 8'h03);
      return 1'b1;
    endfunction

    // Apply one accepted input beat and queue the result it must produce
    function void apply_item(op_t op, logic [7:0] addr, logic [7:0] data);
      result_t     res;
      int unsigned ch;
      int unsigned slot;
      logic [11:0] count_val;
      logic [7:0]  kept;
      logic        restart;
      logic        active;
      logic        hi;
      res = '0;
      case (op)
        OP_TICK: begin
          if (!mode1[M1_SLEEP_BIT]) begin
            if (divider >= prescale) begin
              divider = '0;
              period  = period + 12'd1;
            end else begin
              divider = divider + 8'd1;
            end
          end
        end
        OP_SET_PTR: pointer = addr;
        OP_WRITE: begin
          if (pointer == ADDR_MODE1) begin
            // restart latches on a sleep entry, clears on bit7 written with sleep clear
            kept    = data & MODE1_WMASK;
            restart = mode1[M1_RESTART_BIT];
            if (!mode1[M1_SLEEP_BIT] && kept[M1_SLEEP_BIT]) restart = 1'b1;
            if (data[M1_RESTART_BIT] && !kept[M1_SLEEP_BIT]) restart = 1'b0;
            mode1 = kept;
            mode1[M1_RESTART_BIT] = restart;
          end else if (pointer == ADDR_MODE2) begin
            mode2 = data & MODE2_WMASK;
          end else if (pointer == ADDR_PRESCALE) begin
            if (mode1[M1_SLEEP_BIT]) prescale = (data < PRESCALE_MIN) ? PRESCALE_MIN : data;
          end else if (led_slot(pointer, ch, slot)) begin
            count_val = (slot < 2) ? on_count[ch] : off_count[ch];
            if (slot % 2 == 1) count_val[11:8] = data[3:0];
            else count_val[7:0] = data;
            if (slot < 2) on_count[ch] = count_val;
            else off_count[ch] = count_val;
          end
        end
        OP_READ: begin
          if (pointer == ADDR_MODE1) res.read_data = mode1;
          else if (pointer == ADDR_MODE2) res.read_data = mode2;
          else if (pointer == ADDR_PRESCALE) res.read_data = prescale;
          else if (led_slot(pointer, ch, slot)) begin
            count_val = (slot < 2) ? on_count[ch] : off_count[ch];
            res.read_data = (slot % 2 == 1) ? {4'h0, count_val[11:8]} : count_val[7:0];
          end
        end
      endcase
      // auto-increment after every data byte while AI is set, wrapping at the top of the map
      if ((op == OP_WRITE || op == OP_READ) && mode1[M1_AI_BIT]) pointer = pointer + 8'd1;

      // channel levels: sleep or restart force low, invert applies last
      active = !(mode1[M1_SLEEP_BIT] || mode1[M1_RESTART_BIT]);
      for (int n = 0; n < CHANNELS; n++) begin
        if (on_count[n] < off_count[n])
          hi = (period >= on_count[n]) && (period < off_count[n]);
        else if (on_count[n] > off_count[n])
          hi = (period >= on_count[n]) || (period < off_count[n]);
        else
          hi = 1'b0;
        res.pwm_outputs[n] = (hi && active) ^ mode2[M2_INVRT_BIT];
      end
      res.pwm_count = period;
      predicted_beats.push_back(res);
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void compare_result(logic [7:0] rd, logic [15:0] levels, logic [11:0] count);
      result_t want;
      if (predicted_beats.size() == 0) begin
        $error("result beat arrived with nothing predicted");
        mismatches++;
        return;
      end
      want = predicted_beats.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %02h, actual %02h", want.read_data, rd);
        mismatches++;
      end
      if (levels !== want.pwm_outputs) begin
        $error("pwm_outputs: expected %04h, actual %04h", want.pwm_outputs, levels);
        mismatches++;
      end
      if (count !== want.pwm_count) begin
        $error("pwm_count: expected %03h, actual %03h", want.pwm_count, count);
        mismatches++;
      end
    endfunction
  endclass

  pwm_shadow   shadow;
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  bit          hold_request;
  int unsigned beats_sent;

  pwm_controller_16ch #(.CHANNELS(CHANNELS)) dut (.*);

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one beat, with random idle cycles ahead of it; returns once accepted
  task automatic send_beat(op_t op, logic [7:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_kind        <= op;
    in_reg_address <= addr;
    in_data_byte   <= data;
    do @(posedge clk); while (full);
    shadow.apply_item(op, addr, data);
    beats_sent++;
  endtask

  // Pointer load followed by one data byte
  task automatic write_at(logic [7:0] addr, logic [7:0] data);
    send_beat(OP_SET_PTR, addr, 8'($urandom));
    send_beat(OP_WRITE, 8'($urandom), data);
  endtask

  // Mostly live registers, sometimes anywhere in the map
  function automatic logic [7:0] pick_address();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return ADDR_LED_BASE + 8'($urandom_range(4 * CHANNELS - 1));
    if (pick < 65) return $urandom_range(1) ? ADDR_MODE2 : ADDR_MODE1;
    if (pick < 75) return ADDR_PRESCALE;
    return 8'($urandom);
  endfunction

  // High count byte: usually zero so counts stay within reach of the counter
  function automatic logic [7:0] count_high();
    return ($urandom_range(99) < 70) ? 8'h00 : 8'($urandom);
  endfunction

  // One well-formed register sequence with random content, or a little noise
  task automatic random_sequence();
    int unsigned pick;
    int unsigned ch;
    logic [7:0]  mode_byte;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // program one channel's on and off counts
      ch = $urandom_range(CHANNELS - 1);
      send_beat(OP_SET_PTR, ADDR_LED_BASE + 8'(ch << 2), 8'($urandom));
      send_beat(OP_WRITE, 8'($urandom), 8'($urandom));
      send_beat(OP_WRITE, 8'($urandom), count_high());
      send_beat(OP_WRITE, 8'($urandom), 8'($urandom));
      send_beat(OP_WRITE, 8'($urandom), count_high());
    end else if (pick < 40) begin
      repeat ($urandom_range(30, 4)) send_beat(OP_TICK, 8'($urandom), 8'($urandom));
    end else if (pick < 52) begin
      // mode change, mostly awake with auto-increment
      mode_byte = 8'($urandom);
      mode_byte[M1_AI_BIT]    = ($urandom_range(99) < 85);
      mode_byte[M1_SLEEP_BIT] = ($urandom_range(99) < 20);
      write_at(ADDR_MODE1, mode_byte);
      if ($urandom_range(99) < 30) send_beat(OP_WRITE, 8'($urandom), 8'($urandom));
    end else if (pick < 60) begin
      // sleep, new prescale, wake with restart cleared
      mode_byte = 8'($urandom) & 8'h0F;
      mode_byte[M1_SLEEP_BIT] = 1'b1;
      mode_byte[M1_AI_BIT]    = 1'b1;
      write_at(ADDR_MODE1, mode_byte);
      write_at(ADDR_PRESCALE,
               ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6)));
      mode_byte[M1_SLEEP_BIT]   = 1'b0;
      mode_byte[M1_RESTART_BIT] = 1'b1;
      write_at(ADDR_MODE1, mode_byte);
    end else if (pick < 78) begin
      send_beat(OP_SET_PTR, pick_address(), 8'($urandom));
      repeat ($urandom_range(6, 1)) send_beat(OP_READ, 8'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      write_at(pick_address(), 8'($urandom));
    end else begin
      repeat ($urandom_range(4, 1))
        send_beat(op_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned held;
    held = 0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) shadow.compare_result(out_read_data, out_pwm_outputs, out_pwm_count);
      if (hold_request) begin
        hold_request = 1'b0;
        held = 64;
      end
      if (held != 0) begin
        held--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase_start;
    shadow         = new();
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    hold_request   = 1'b0;
    beats_sent     = 0;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_kind        <= OP_TICK;
    in_reg_address <= '0;
    in_data_byte   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, ticks ignored while asleep, prescale clamp
    send_beat(OP_READ, 8'hFF, 8'hFF);
    send_beat(OP_TICK, 8'h00, 8'h00);
    write_at(ADDR_PRESCALE, 8'h00);
    send_beat(OP_READ, 8'h00, 8'h00);
    // wake with auto-increment; bit7 set with sleep clear keeps restart clear
    write_at(ADDR_MODE1, 8'hA1);
    // MODE2 with every bit set: invert on, upper bits dropped
    send_beat(OP_WRITE, 8'h00, 8'hFF);
    // channel 0: on 0, off 2, junk in the upper nibble of OFF_H
    send_beat(OP_SET_PTR, ADDR_LED_BASE, 8'h00);
    send_beat(OP_WRITE, 8'h00, 8'h00);
    send_beat(OP_WRITE, 8'h00, 8'h00);
    send_beat(OP_WRITE, 8'h00, 8'h02);
    send_beat(OP_WRITE, 8'h00, 8'hF0);
    // last channel: on above off, so it wraps around the period
    send_beat(OP_SET_PTR, ADDR_LED_BASE + 8'(4 * (CHANNELS - 1)), 8'hFF);
    send_beat(OP_WRITE, 8'hFF, 8'hFF);
    send_beat(OP_WRITE, 8'hFF, 8'hFF);
    send_beat(OP_WRITE, 8'hFF, 8'h01);
    send_beat(OP_WRITE, 8'hFF, 8'h00);
    // pointer now past the last channel: unmapped write
    send_beat(OP_WRITE, 8'h00, 8'h77);
    // prescale write while awake is dropped; read at the top wraps the pointer
    write_at(ADDR_PRESCALE, 8'h10);
    send_beat(OP_READ, 8'h00, 8'h00);
    repeat (6) send_beat(OP_TICK, 8'($urandom), 8'($urandom));

    // random phases with different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          hold_request  = 1'b1;
        end
        1: begin
          send_idle_pct = 45;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 6;
          pop_stall_pct = 6;
        end
      endcase
      phase_start = beats_sent;
      while (beats_sent < phase_start + PHASE_BEATS) random_sequence();
    end

    // tick run at the fastest prescale, with an occasional read mixed in
    send_idle_pct = 0;
    pop_stall_pct = 0;
    write_at(ADDR_MODE1, 8'h30);   // sleep + auto-increment
    write_at(ADDR_PRESCALE, PRESCALE_MIN);
    write_at(ADDR_MODE1, 8'hA0);   // wake, restart cleared
    repeat (FAST_TICKS) begin
      if ($urandom_range(15) == 0) send_beat(OP_READ, 8'($urandom), 8'($urandom));
      else send_beat(OP_TICK, 8'($urandom), 8'($urandom));
    end
    push <= 1'b0;

    // drain, then allow for the pipeline latency
    while (shadow.predicted_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("** pwm_controller_16ch: PASSED **");
    end else begin
      $display("** pwm_controller_16ch: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** pwm_controller_16ch: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/pwmc_pkg.sv
rtl/pwmc_fifo.sv
rtl/pwmc_front.sv
rtl/pwmc_back.sv
rtl/pwm_controller_16ch.sv
tb/sv/tb_pwm_controller_16ch.sv
